// ===== hdl/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types and codes for the bully-style leader election node.
// ----------------------------------------------------------------------------
package ble_pkg;

  // Node count limit; node ids are 4 bits, so the cluster never exceeds 16
  localparam int MAX_NODES = 16;
  localparam logic [4:0] NODE_CAP = 5'((MAX_NODES < 16) ? MAX_NODES : 16);

  // Configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 8;
  localparam logic [CFG_AW-1:0] CFG_NODE_ID       = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_CLUSTER_SIZE  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_ELECTION_WAIT = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_VICTORY_WAIT  = 2'd3;

  // Input opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_MSG   = 2'd2;

  // Message codes
  localparam logic [1:0] CODE_ELECTION = 2'd0;
  localparam logic [1:0] CODE_ALIVE    = 2'd1;
  localparam logic [1:0] CODE_VICTORY  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_SEND   = 2'd1;
  localparam logic [1:0] KIND_LEADER = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_REPLY,
    PH_WAIT_VICTORY,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    JOB_STATUS,
    JOB_LEADER,
    JOB_ELECT,
    JOB_ALIVE_ELECT,
    JOB_VICTORY
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [3:0] src;
    logic [3:0] ldr;
  } job_t;

  typedef struct packed {
    logic [3:0] node_id;
    logic [4:0] cluster_size;
    logic [7:0] election_wait;
    logic [7:0] victory_wait;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ALIVE,
    BK_SWEEP,
    BK_FINAL
  } bk_state_t;

endpackage

// ===== hdl/ble_if.sv =====
// ----------------------------------------------------------------------------
// ble_in_if / ble_out_if
// Valid/ready channels for election requests and results.
// ----------------------------------------------------------------------------
interface ble_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] src_node;
  logic [1:0] msg_code;

  modport source(output valid, opcode, src_node, msg_code, input ready);
  modport sink(input valid, opcode, src_node, msg_code, output ready);
endinterface

interface ble_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] dst_node;
  logic [1:0] out_code;
  logic [3:0] leader_node;
  logic       last;

  modport source(output valid, kind, dst_node, out_code, leader_node, last, input ready);
  modport sink(input valid, kind, dst_node, out_code, leader_node, last, output ready);
endinterface

// ===== hdl/bully_leader_election.sv =====
// ----------------------------------------------------------------------------
// bully_leader_election
// One node of a bully-style leader election with a decoupled front and back.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request per handshake: start, one-second tick, or a
//   received message (sender and code). res returns the results of each
//   request in order, one per handshake; last marks the final one.
//   cfg_we/cfg_idx/cfg_data write node_id, cluster_size, election_wait and
//   victory_wait; write them only while no request is in flight.
// Timing:
//   The front updates the election state in the accept cycle and queues a
//   job in a four-entry queue. The back takes a job from the queue only
//   when idle, once all results of the previous job have gone out, then
//   produces that job's results in order into the output register,
//   holding while res is stalled. A victory broadcast also spends steps on
//   skipping this node's own id (when it lies in the cluster) and on
//   ending the sweep. The back's single result sequencer sets the rate.
// Reset:
//   rst clears phase, timer, leader, the queue and the output register, and
//   loads the register defaults. A stalled res holds its item; the queue
//   keeps req accepting until four jobs are pending.
// ----------------------------------------------------------------------------
module bully_leader_election (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ble_pkg::CFG_AW-1:0] cfg_idx,
  input  logic [ble_pkg::CFG_DW-1:0] cfg_data,
  ble_in_if.sink                     req,
  ble_out_if.source                  res
);
  import ble_pkg::*;

  cfg_t cfg;
  job_t push_job, pop_job;
  logic q_push, q_full, q_pop, q_nonempty;

  // Configuration registers; hold between writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_id       <= 4'd0;
      cfg.cluster_size  <= 5'd16;
      cfg.election_wait <= 8'd5;
      cfg.victory_wait  <= 8'd60;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_NODE_ID:       cfg.node_id       <= cfg_data[3:0];
        CFG_CLUSTER_SIZE:  cfg.cluster_size  <= cfg_data[4:0];
        CFG_ELECTION_WAIT: cfg.election_wait <= cfg_data;
        CFG_VICTORY_WAIT:  cfg.victory_wait  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: accept and classify the request, advance the election state
  ble_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  // Queue: decouple the front from a stalled back
  ble_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .nonempty (q_nonempty)
  );

  // Back: expand each job into its sequence of results
  ble_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (q_nonempty),
    .job       (pop_job),
    .job_pop   (q_pop),
    .res       (res)
  );

endmodule

// ===== hdl/ble_front.sv =====
// ----------------------------------------------------------------------------
// ble_front
// Accepts requests, runs the election state and queues result jobs.
// ----------------------------------------------------------------------------
module ble_front (
  input  logic          clk,
  input  logic          rst,
  input  ble_pkg::cfg_t cfg,
  ble_in_if.sink        req,
  input  logic          q_full,
  output logic          q_push,
  output ble_pkg::job_t q_job
);
  import ble_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] wait_timer, wait_timer_next;
  logic [3:0] leader, leader_next;
  logic       waiting;

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;
  assign waiting   = (phase == PH_WAIT_REPLY) || (phase == PH_WAIT_VICTORY);

  always_comb begin
    phase_next      = phase;
    wait_timer_next = wait_timer;
    leader_next     = leader;
    q_job.kind      = JOB_STATUS;
    q_job.src       = req.src_node;
    q_job.ldr       = leader;
    if (req.opcode == OP_START) begin
      q_job.kind      = JOB_ELECT;
      phase_next      = PH_WAIT_REPLY;
      wait_timer_next = cfg.election_wait;
    end else if (req.opcode == OP_TICK && waiting) begin
      if (wait_timer <= 8'd1) begin
        q_job.kind      = JOB_VICTORY;
        q_job.ldr       = cfg.node_id;
        leader_next     = cfg.node_id;
        phase_next      = PH_DONE;
        wait_timer_next = '0;
      end else begin
        wait_timer_next = wait_timer - 8'd1;
      end
    end else if (req.opcode == OP_MSG && waiting) begin
      if (req.msg_code == CODE_ELECTION) begin
        q_job.kind      = JOB_ALIVE_ELECT;
        phase_next      = PH_WAIT_REPLY;
        wait_timer_next = cfg.election_wait;
      end else if (req.msg_code == CODE_ALIVE) begin
        phase_next      = PH_WAIT_VICTORY;
        wait_timer_next = cfg.victory_wait;
      end else if (req.msg_code == CODE_VICTORY) begin
        q_job.kind      = JOB_LEADER;
        q_job.ldr       = req.src_node;
        leader_next     = req.src_node;
        phase_next      = PH_DONE;
        wait_timer_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_timer <= '0;
      leader     <= '0;
    end else if (q_push) begin
      phase      <= phase_next;
      wait_timer <= wait_timer_next;
      leader     <= leader_next;
    end
  end

endmodule

// ===== hdl/ble_fifo.sv =====
// ----------------------------------------------------------------------------
// ble_fifo
// Four-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module ble_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ble_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output ble_pkg::job_t pop_job,
  output logic          nonempty
);
  import ble_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  job_t          slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign full     = (count == (AW+1)'(DEPTH));
  assign nonempty = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

// ===== hdl/ble_back.sv =====
// ----------------------------------------------------------------------------
// ble_back
// Expands queued jobs into result items, at most one per cycle, into an output register.
// ----------------------------------------------------------------------------
module ble_back (
  input  logic          clk,
  input  logic          rst,
  input  ble_pkg::cfg_t cfg,
  input  logic          job_valid,
  input  ble_pkg::job_t job,
  output logic          job_pop,
  ble_out_if.source     res
);
  import ble_pkg::*;

  bk_state_t  state, state_next;
  job_kind_t  jkind, jkind_next;
  logic [3:0] jsrc, jsrc_next;
  logic [3:0] jldr, jldr_next;
  logic [4:0] dst, dst_next;

  logic       ovalid;
  logic [1:0] okind, ocode;
  logic [3:0] odst, oldr;
  logic       olast;

  logic       out_free;
  logic       emit;
  logic [1:0] e_kind, e_code;
  logic [3:0] e_dst, e_ldr;
  logic       e_last;

  logic [4:0] nodes;
  logic [4:0] first_hi;
  logic       has_higher;
  logic [4:0] dst_inc;

  assign nodes      = (cfg.cluster_size > NODE_CAP) ? NODE_CAP : cfg.cluster_size;
  assign first_hi   = {1'b0, cfg.node_id} + 5'd1;
  assign has_higher = first_hi < nodes;
  assign dst_inc    = dst + 5'd1;
  assign out_free   = !ovalid || res.ready;

  always_comb begin
    state_next = state;
    jkind_next = jkind;
    jsrc_next  = jsrc;
    jldr_next  = jldr;
    dst_next   = dst;
    job_pop    = 1'b0;
    emit       = 1'b0;
    e_kind     = KIND_STATUS;
    e_dst      = '0;
    e_code     = CODE_ELECTION;
    e_ldr      = '0;
    e_last     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          jkind_next = job.kind;
          jsrc_next  = job.src;
          jldr_next  = job.ldr;
          unique case (job.kind)
            JOB_STATUS, JOB_LEADER: state_next = BK_FINAL;
            JOB_ELECT: begin
              if (has_higher) begin
                state_next = BK_SWEEP;
                dst_next   = first_hi;
              end else begin
                jkind_next = JOB_STATUS;
                state_next = BK_FINAL;
              end
            end
            JOB_ALIVE_ELECT: state_next = BK_ALIVE;
            JOB_VICTORY: begin
              state_next = BK_SWEEP;
              dst_next   = '0;
            end
            default: state_next = BK_FINAL;
          endcase
        end
      end
      BK_ALIVE: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = KIND_SEND;
          e_dst  = jsrc;
          e_code = CODE_ALIVE;
          e_last = !has_higher;
          if (has_higher) begin
            jkind_next = JOB_ELECT;
            dst_next   = first_hi;
            state_next = BK_SWEEP;
          end else begin
            state_next = BK_IDLE;
          end
        end
      end
      BK_SWEEP: begin
        if (jkind == JOB_VICTORY) begin
          if (dst >= nodes) begin
            state_next = BK_FINAL;
          end else if (dst == {1'b0, cfg.node_id}) begin
            // skip this node itself
            dst_next = dst_inc;
          end else if (out_free) begin
            emit     = 1'b1;
            e_kind   = KIND_SEND;
            e_dst    = dst[3:0];
            e_code   = CODE_VICTORY;
            dst_next = dst_inc;
          end
        end else if (out_free) begin
          emit     = 1'b1;
          e_kind   = KIND_SEND;
          e_dst    = dst[3:0];
          e_code   = CODE_ELECTION;
          e_last   = dst_inc >= nodes;
          dst_next = dst_inc;
          if (dst_inc >= nodes) begin
            state_next = BK_IDLE;
          end
        end
      end
      BK_FINAL: begin
        if (out_free) begin
          emit       = 1'b1;
          e_kind     = (jkind == JOB_STATUS) ? KIND_STATUS : KIND_LEADER;
          e_ldr      = jldr;
          e_last     = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    jkind <= jkind_next;
    jsrc  <= jsrc_next;
    jldr  <= jldr_next;
    dst   <= dst_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_free) begin
      ovalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      okind <= e_kind;
      odst  <= e_dst;
      ocode <= e_code;
      oldr  <= e_ldr;
      olast <= e_last;
    end
  end

  assign res.valid       = ovalid;
  assign res.kind        = okind;
  assign res.dst_node    = odst;
  assign res.out_code    = ocode;
  assign res.leader_node = oldr;
  assign res.last        = olast;

endmodule

// ===== hdl/ble_checker.sv =====
// ----------------------------------------------------------------------------
// ble_checker
// Port-level checks on the election node's result channel.
// ----------------------------------------------------------------------------
module ble_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [1:0] res_kind,
  input logic [3:0] res_dst,
  input logic [1:0] res_code,
  input logic [3:0] res_ldr,
  input logic       res_last
);
  import ble_pkg::*;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // Drop any result after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // A leader result closes the sequence of its request
  a_leader_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_kind == KIND_LEADER |-> res_last)
    else $error("leader result not marked last");

  // Unused fields read as zero
  a_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_kind == KIND_SEND) ? (res_ldr == 4'd0)
                                          : (res_dst == 4'd0 && res_code == 2'd0))
    else $error("unused result field not zero");

endmodule

bind bully_leader_election ble_checker u_ble_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_kind  (res.kind),
  .res_dst   (res.dst_node),
  .res_code  (res.out_code),
  .res_ldr   (res.leader_node),
  .res_last  (res.last)
);

// ===== sim/tb_bully_leader_election.sv =====
// ----------------------------------------------------------------------------
// tb_bully_leader_election
// Self-checking bench for one node of the bully-style leader election. A
// driver feeds requests (start, tick, received message) from a queue, and a
// built-in predictor works out each request's results. A monitor then checks
// every returned result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bully_leader_election;
  timeunit 1ns;
  timeprecision 1ps;

  import ble_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int MAX_RESULTS  = 16;      // most results one request can cause
  localparam int SETTLE_WAIT  = 24;      // back end latency plus margin
  localparam int LONG_HOLD    = 400;     // long result-side stall
  localparam int CYCLE_LIMIT  = 600_000;
  localparam int SHOWN_ERRORS = 10;

  // One request as it sits in the pending queue; drain holds it back until
  // every predicted result has been returned.
  typedef struct packed {
    logic [1:0] op;
    logic [3:0] src;
    logic [1:0] code;
    logic       drain;
  } node_ev_t;

  // One result of the node
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] dst;
    logic [1:0] code;
    logic [3:0] ldr;
    logic       last;
  } node_out_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_data;

  ble_in_if  req_ch ();
  ble_out_if res_ch ();

  bully_leader_election uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .res      (res_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Pending requests and predicted results
  node_ev_t  event_q[$];
  node_out_t predicted_out[$];
  node_out_t step_out[$];

  // Predictor's copy of the registers and of the election state
  logic [3:0] my_id;
  logic [4:0] n_size;
  logic [7:0] ew_len;
  logic [7:0] vw_len;
  phase_t     node_phase;
  logic [7:0] wait_left;
  logic [3:0] leader_id;

  int  mismatches = 0;
  int  cycles = 0;
  bit  req_took = 1'b0;
  bit  calm = 1'b0;           // no idling on either side while set
  int  send_gap = 0;
  int  sink_gap = 0;
  int  hold_left = 0;
  int  hold_requests = 0;
  int  holds_served = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Clamp the cluster to what 4-bit node ids can address
  function automatic int node_count();
    return (n_size > NODE_CAP) ? int'(NODE_CAP) : int'(n_size);
  endfunction

  // Stage one result of the current request; drop anything past the cap
  function automatic void stage_out(logic [1:0] kind, logic [3:0] dst,
                                    logic [1:0] code, logic [3:0] ldr);
    node_out_t r;
    r = '{kind: kind, dst: dst, code: code, ldr: ldr, last: 1'b0};
    if (step_out.size() < MAX_RESULTS) step_out.push_back(r);
  endfunction

  // Send ELECTION to every higher node and arm the reply wait
  function automatic void open_election();
    int n;
    n = node_count();
    for (int d = int'(my_id) + 1; d < n; d++) begin
      stage_out(KIND_SEND, 4'(d), CODE_ELECTION, 4'd0);
    end
    node_phase = PH_WAIT_REPLY;
    wait_left  = ew_len;
  endfunction

  // Advance the node by one accepted request and queue its results
  function automatic void apply_event(logic [1:0] op, logic [3:0] src, logic [1:0] code);
    logic      waiting;
    int        n;
    node_out_t r;
    step_out.delete();
    waiting = (node_phase == PH_WAIT_REPLY) || (node_phase == PH_WAIT_VICTORY);
    case (op)
      OP_START: begin
        // a start always abandons whatever was going on
        open_election();
      end
      OP_TICK: begin
        if (waiting) begin
          if (wait_left <= 8'd1) begin
            // timeout: broadcast VICTORY and take the lead
            n = node_count();
            for (int d = 0; d < n; d++) begin
              if (d != int'(my_id)) stage_out(KIND_SEND, 4'(d), CODE_VICTORY, 4'd0);
            end
            leader_id  = my_id;
            node_phase = PH_DONE;
            wait_left  = 8'd0;
            stage_out(KIND_LEADER, 4'd0, CODE_ELECTION, leader_id);
          end else begin
            wait_left = wait_left - 8'd1;
          end
        end
      end
      OP_MSG: begin
        if (waiting) begin
          case (code)
            CODE_ELECTION: begin
              stage_out(KIND_SEND, src, CODE_ALIVE, 4'd0);
              open_election();
            end
            CODE_ALIVE: begin
              node_phase = PH_WAIT_VICTORY;
              wait_left  = vw_len;
            end
            CODE_VICTORY: begin
              leader_id  = src;
              node_phase = PH_DONE;
              wait_left  = 8'd0;
              stage_out(KIND_LEADER, 4'd0, CODE_ELECTION, leader_id);
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    if (step_out.size() == 0) stage_out(KIND_STATUS, 4'd0, CODE_ELECTION, leader_id);
    foreach (step_out[i]) begin
      r = step_out[i];
      r.last = (i == step_out.size() - 1);
      predicted_out.push_back(r);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly short gaps, some none, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_ev(logic [1:0] op, logic [3:0] src, logic [1:0] code,
                                  logic drain = 1'b0);
    node_ev_t e;
    e = '{op: op, src: src, code: code, drain: drain};
    event_q.push_back(e);
  endfunction

  // Queue one election episode: a start, then ticks and messages with random
  // content, with a little noise mixed in. Return the number of requests.
  function automatic int queue_episode();
    int len;
    int r;
    logic drain;
    push_ev(OP_START, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
    len = $urandom_range(2, 9);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      drain = ($urandom_range(0, 29) == 0);
      if (r < 45)      push_ev(OP_TICK, 4'($urandom_range(0, 15)),
                               2'($urandom_range(0, 3)), drain);
      else if (r < 60) push_ev(OP_MSG, 4'($urandom_range(0, 15)), CODE_ALIVE, drain);
      else if (r < 70) push_ev(OP_MSG, 4'($urandom_range(0, 15)), CODE_ELECTION, drain);
      else if (r < 78) push_ev(OP_MSG, 4'($urandom_range(0, 15)), CODE_VICTORY, drain);
      else if (r < 81) push_ev(2'd3, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
      else if (r < 84) push_ev(OP_MSG, 4'($urandom_range(0, 15)), 2'd3);
      else if (r < 90) push_ev(OP_START, 4'($urandom_range(0, 15)),
                               2'($urandom_range(0, 3)));
      else             push_ev(OP_TICK, 4'($urandom_range(0, 15)), CODE_ELECTION);
    end
    return len + 1;
  endfunction

  // Wait until nothing is pending or in flight, then let the back end settle.
  // Check on the rising edge, where the driver's outputs are already stable.
  task automatic settle();
    do @(posedge clk);
    while (event_q.size() != 0 || req_ch.valid || predicted_out.size() != 0);
    repeat (SETTLE_WAIT) @(negedge clk);
  endtask

  // Write one register and track it in the predictor
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_NODE_ID:       my_id  = val[3:0];
      CFG_CLUSTER_SIZE:  n_size = val[4:0];
      CFG_ELECTION_WAIT: ew_len = val;
      CFG_VICTORY_WAIT:  vw_len = val;
      default: ;
    endcase
  endtask

  task automatic set_node_cfg(logic [3:0] id, logic [4:0] size, logic [7:0] ew,
                              logic [7:0] vw);
    write_reg(CFG_NODE_ID, CFG_DW'(id));
    write_reg(CFG_CLUSTER_SIZE, CFG_DW'(size));
    write_reg(CFG_ELECTION_WAIT, ew);
    write_reg(CFG_VICTORY_WAIT, vw);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Request driver: present the next pending request once the previous one
  // has been taken, after a random gap. Drive on the falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : req_driver
    node_ev_t e;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_took) begin
      if (send_gap > 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (event_q.size() != 0 &&
                   !(event_q[0].drain && predicted_out.size() != 0)) begin
        e = event_q.pop_front();
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= e.op;
        req_ch.src_node <= e.src;
        req_ch.msg_code <= e.code;
        send_gap = pick_gap();
      end else begin
        // nothing to offer yet, or holding until the node has drained
        req_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result ready: random stalls, plus one long hold-off on request so the
  // job queue fills up and the node stops taking requests.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : res_ready
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LONG_HOLD - 1;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      sink_gap = pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample both handshakes on the rising edge. An accepted request
  // advances the predictor; an accepted result is checked against the
  // oldest prediction.
  // --------------------------------------------------------------------------
  task automatic note_mismatch(string what, node_out_t want, node_out_t got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) begin
      $display("%0t: %s: want kind=%0d dst=%0d code=%0d leader=%0d last=%0d",
               $realtime, what, want.kind, want.dst, want.code, want.ldr, want.last);
      $display("%0t: %s: got  kind=%0d dst=%0d code=%0d leader=%0d last=%0d",
               $realtime, what, got.kind, got.dst, got.code, got.ldr, got.last);
    end
  endtask

  always @(posedge clk) begin : monitor
    node_out_t got;
    node_out_t want;
    if (rst) begin
      req_took = 1'b0;
    end else begin
      req_took = req_ch.valid && req_ch.ready;
      if (req_took) apply_event(req_ch.opcode, req_ch.src_node, req_ch.msg_code);
      if (res_ch.valid && res_ch.ready) begin
        got = '{kind: res_ch.kind, dst: res_ch.dst_node, code: res_ch.out_code,
                ldr: res_ch.leader_node, last: res_ch.last};
        if (predicted_out.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = predicted_out.pop_front();
          if (got.kind !== want.kind || got.dst !== want.dst || got.code !== want.code ||
              got.ldr !== want.ldr || got.last !== want.last) begin
            note_mismatch("result mismatch", want, got);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : sequencer
    int         total;
    logic [3:0] id;
    logic [4:0] size;

    // Drive every input to a known value from time zero
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    req_ch.valid    = 1'b0;
    req_ch.opcode   = OP_START;
    req_ch.src_node = 4'd0;
    req_ch.msg_code = CODE_ELECTION;
    res_ch.ready    = 1'b0;

    // Predictor starts from the reset defaults
    my_id      = 4'd0;
    n_size     = 5'd16;
    ew_len     = 8'd5;
    vw_len     = 8'd60;
    node_phase = PH_IDLE;
    wait_left  = 8'd0;
    leader_id  = 4'd0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Defaults: node 0 of 16, so every election goes to fifteen nodes.
    // Idle node ignores ticks, messages and an unknown opcode.
    push_ev(OP_TICK, 4'd0, CODE_ELECTION);
    push_ev(OP_MSG, 4'd15, CODE_ELECTION);
    push_ev(2'd3, 4'd15, 2'd3);
    push_ev(OP_START, 4'd0, CODE_ELECTION);
    // unknown message code while waiting: ignored
    push_ev(OP_MSG, 4'd7, 2'd3);
    // ALIVE starts the victory wait, a second one restarts it
    push_ev(OP_MSG, 4'd15, CODE_ALIVE);
    push_ev(OP_MSG, 4'd9, CODE_ALIVE);
    // ELECTION from above: answer ALIVE and restart the full sweep
    push_ev(OP_MSG, 4'd15, CODE_ELECTION);
    push_ev(OP_MSG, 4'd15, CODE_VICTORY);
    push_ev(OP_TICK, 4'd3, CODE_VICTORY);
    // hold the sender until the node has drained, then time out the wait
    push_ev(OP_START, 4'd10, CODE_ALIVE, 1'b1);
    repeat (5) push_ev(OP_TICK, 4'd0, CODE_ELECTION);
    settle();

    // Top node, oversized cluster, zero election wait: no ELECTION goes out
    // and the next tick wins at once.
    set_node_cfg(4'd15, 5'd31, 8'd0, 8'd255);
    push_ev(OP_START, 4'd5, CODE_ELECTION);
    push_ev(OP_TICK, 4'd0, CODE_ELECTION);
    push_ev(OP_START, 4'd0, CODE_ELECTION);
    push_ev(OP_MSG, 4'd0, CODE_ALIVE);
    push_ev(OP_TICK, 4'd0, CODE_ELECTION);
    push_ev(OP_MSG, 4'd0, CODE_ELECTION);
    settle();

    // Node id beyond the cluster: VICTORY goes to every member
    set_node_cfg(4'd5, 5'd3, 8'd1, 8'd1);
    push_ev(OP_START, 4'd0, CODE_ELECTION);
    push_ev(OP_TICK, 4'd0, CODE_ELECTION);
    push_ev(OP_MSG, 4'd3, CODE_VICTORY);
    settle();

    // Random phases: fresh settings each time, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      id   = 4'($urandom_range(0, 15));
      size = 5'($urandom_range(0, 31));
      case (ph)
        0: begin id = 4'd0; size = 5'd1; end
        3: size = 5'd0;
        4: size = 5'd16;
        default: ;
      endcase
      set_node_cfg(id, size, 8'($urandom_range(0, 4)), 8'($urandom_range(0, 6)));
      calm = (ph == 1);
      // stall the result side for a long stretch while requests keep coming
      if (ph == 2) hold_requests++;
      total = 0;
      while (total < 28) total += queue_episode();
      settle();
    end
    calm = 1'b0;

    mismatches += predicted_out.size();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
